### design/nrsm_pkg.sv
// Package for the NFA stream matcher: entry layout, codes and sequencer states.
`default_nettype none
package nrsm_pkg;

    // Input item modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_SYMBOL = 2'd2;

    // Table entry kinds
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_SPLIT   = 2'd1;
    localparam logic [1:0] KIND_MATCH   = 2'd2;

    // Successor field width and the first code that means no successor
    localparam int unsigned SUCC_W    = 7;
    localparam int unsigned SUCC_NONE = 64;

    // Entry layout {kind, symbol, next_a, next_b}
    localparam int unsigned ENTRY_W = 24;

    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_CLOSE,
        ST_SCORE,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

### design/nfa_regex_stream_matcher_unit.sv
// Top level of the NFA stream matcher: table memory, active set and scan sequencer.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_data (start state)         | in
//  in      | in_valid, in_ready, mode, entry_index, entry_kind,   | in
//          | entry_symbol, next_a, next_b, symbol                 |
//  out     | out_valid, out_ready, matched, set_empty             | out
//
// One table read port scans the entries, one entry a cycle. A write or no-op beat runs a
// score scan; a start beat runs closure passes until no state is pending, then a score scan;
// a symbol beat runs a step scan before those. Extra closure passes come from split chains
// that lead back to a lower table index.
// Reset clears the active set and start state; the table is undefined until written.
// in_ready is low from acceptance until the result beat is taken; a stalled result holds.
`default_nettype none
module nfa_regex_stream_matcher_unit
    import nrsm_pkg::*;
#(
    parameter int unsigned NUM_STATES = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [5:0]       cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       mode,
    input  wire logic [5:0]       entry_index,
    input  wire logic [1:0]       entry_kind,
    input  wire logic [7:0]       entry_symbol,
    input  wire logic [6:0]       next_a,
    input  wire logic [6:0]       next_b,
    input  wire logic [7:0]       symbol,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  matched,
    output logic                  set_empty
);

    localparam int unsigned IDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_STATES);

    // Map a successor code to a table index
    function automatic logic [IDX_W-1:0] succ_idx(input logic [SUCC_W-1:0] s);
        logic [IDX_W+SUCC_W-1:0] w;
        w = {{IDX_W{1'b0}}, s};
        return w[IDX_W-1:0];
    endfunction

    // A successor code names a real state
    function automatic logic succ_ok(input logic [SUCC_W-1:0] s);
        return (32'(s) < SUCC_NONE) && (32'(s) < NUM_STATES);
    endfunction

    entry_t                  mem [NUM_STATES];

    state_t                  state_reg, state_next;
    logic [5:0]              start_state_reg;
    logic [CNT_W-1:0]        addr_reg, addr_next;
    logic                    ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]        ev_idx_reg, ev_idx_next;
    entry_t                  rd_data_reg;
    logic [NUM_STATES-1:0]   cur_reg, cur_next;
    logic [NUM_STATES-1:0]   nxt_reg, nxt_next;
    logic [NUM_STATES-1:0]   pend_reg, pend_next;
    logic [7:0]              sym_reg, sym_next;
    logic                    hit_reg, hit_next;
    logic                    any_reg, any_next;
    logic                    matched_reg, matched_next;
    logic                    set_empty_reg, set_empty_next;

    logic                    in_accept;
    logic                    scanning;
    logic                    issue;
    logic                    scan_done;
    logic                    pend_any;
    logic                    wr_en;
    logic [1:0]              ev_kind;
    logic [7:0]              ev_sym;
    logic [SUCC_W-1:0]       ev_na;
    logic [SUCC_W-1:0]       ev_nb;
    logic [IDX_W-1:0]        na_idx;
    logic [IDX_W-1:0]        nb_idx;
    logic [IDX_W-1:0]        start_idx;

    // Decode handshakes and scan control
    assign in_accept = in_valid && in_ready;
    assign scanning  = (state_reg == ST_STEP) || (state_reg == ST_CLOSE)
                       || (state_reg == ST_SCORE);
    assign issue     = scanning && (addr_reg < SCAN_END);
    assign scan_done = (addr_reg == SCAN_END) && !ev_vld_reg;
    assign pend_any  = |pend_reg;
    assign wr_en     = in_accept && (mode == MODE_WRITE)
                       && (32'(entry_index) < NUM_STATES);

    assign ev_kind   = rd_data_reg[23:22];
    assign ev_sym    = rd_data_reg[21:14];
    assign ev_na     = rd_data_reg[13:7];
    assign ev_nb     = rd_data_reg[6:0];
    assign na_idx    = succ_idx(ev_na);
    assign nb_idx    = succ_idx(ev_nb);
    assign start_idx = succ_idx({1'b0, start_state_reg});

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[succ_idx({1'b0, entry_index})] <= {entry_kind, entry_symbol, next_a, next_b};
        end
        if (issue)
        begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (mode)
                        MODE_START:  state_next = ST_CLOSE;
                        MODE_SYMBOL: state_next = ST_STEP;
                        default:     state_next = ST_SCORE;
                    endcase
                end
            end
            ST_STEP:
            begin
                if (scan_done)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if (scan_done && !pend_any)
                begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_DONE);
        cfg_ready = 1'b1;
        matched   = matched_reg;
        set_empty = set_empty_reg;
    end

    // Datapath: seed, advance and close the active set, then score it
    always_comb
    begin
        addr_next      = addr_reg;
        ev_vld_next    = issue;
        ev_idx_next    = addr_reg[IDX_W-1:0];
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        pend_next      = pend_reg;
        sym_next       = sym_reg;
        hit_next       = hit_reg;
        any_next       = any_reg;
        matched_next   = matched_reg;
        set_empty_next = set_empty_reg;

        if (issue)
        begin
            addr_next = addr_reg + CNT_W'(1);
        end

        // Seed a new item
        if (in_accept)
        begin
            addr_next = '0;
            hit_next  = 1'b0;
            any_next  = 1'b0;
            sym_next  = symbol;
            nxt_next  = '0;
            pend_next = '0;
            if ((mode == MODE_START) && (32'(start_state_reg) < NUM_STATES))
            begin
                nxt_next[start_idx]  = 1'b1;
                pend_next[start_idx] = 1'b1;
            end
        end

        // Evaluate the entry read last cycle
        if (ev_vld_reg)
        begin
            case (state_reg)
                ST_STEP:
                begin
                    if (cur_reg[ev_idx_reg] && (ev_kind == KIND_LITERAL)
                        && (ev_sym == sym_reg) && succ_ok(ev_na) && !nxt_next[na_idx])
                    begin
                        nxt_next[na_idx]  = 1'b1;
                        pend_next[na_idx] = 1'b1;
                    end
                end
                ST_CLOSE:
                begin
                    if (pend_reg[ev_idx_reg])
                    begin
                        pend_next[ev_idx_reg] = 1'b0;
                        if (ev_kind == KIND_SPLIT)
                        begin
                            if (succ_ok(ev_na) && !nxt_next[na_idx])
                            begin
                                nxt_next[na_idx]  = 1'b1;
                                pend_next[na_idx] = 1'b1;
                            end
                            if (succ_ok(ev_nb) && !nxt_next[nb_idx])
                            begin
                                nxt_next[nb_idx]  = 1'b1;
                                pend_next[nb_idx] = 1'b1;
                            end
                        end
                    end
                end
                ST_SCORE:
                begin
                    if (cur_reg[ev_idx_reg])
                    begin
                        any_next = 1'b1;
                        if (ev_kind == KIND_MATCH)
                        begin
                            hit_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Close a scan
        if (scan_done)
        begin
            addr_next = '0;
            if ((state_reg == ST_CLOSE) && !pend_any)
            begin
                cur_next = nxt_reg;
            end
            if (state_reg == ST_SCORE)
            begin
                matched_next   = hit_reg;
                set_empty_next = !any_reg;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            start_state_reg <= '0;
            addr_reg        <= '0;
            ev_vld_reg      <= 1'b0;
            cur_reg         <= '0;
            nxt_reg         <= '0;
            pend_reg        <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            ev_vld_reg <= ev_vld_next;
            cur_reg    <= cur_next;
            nxt_reg    <= nxt_next;
            pend_reg   <= pend_next;
            if (cfg_valid && cfg_ready)
            begin
                start_state_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ev_idx_reg    <= ev_idx_next;
        sym_reg       <= sym_next;
        hit_reg       <= hit_next;
        any_reg       <= any_next;
        matched_reg   <= matched_next;
        set_empty_reg <= set_empty_next;
    end

endmodule
`default_nettype wire

### design/nrsm_checker.sv
// Port checker for the NFA stream matcher and its bind to the top level.
`default_nettype none
module nrsm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       matched,
    input wire logic       set_empty
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(set_empty))
        else $error("result beat changed while stalled");

    // No item is taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid)
        else $error("item accepted with a result pending");

    // The block goes busy after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("not busy after accepting an item");

    // One result per item: the result drops once taken
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid && in_ready)
        else $error("result repeated after delivery");

endmodule

bind nfa_regex_stream_matcher_unit nrsm_checker u_nrsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .matched   (matched),
    .set_empty (set_empty)
);
`default_nettype wire

### test/nfa_regex_stream_matcher_unit_tb.sv
// Self-checking testbench for the NFA stream matcher: table loads, string runs, start states.
`timescale 1ns / 1ps
module nfa_regex_stream_matcher_unit_tb
    import nrsm_pkg::*;
();

    localparam int unsigned NUM_STATES = 64;
    localparam logic [1:0]  MODE_NOP   = 2'd3;
    localparam logic [1:0]  KIND_DEAD  = 2'd3;
    localparam int          CYCLE_CAP  = 12_000_000;
    localparam int          LONG_HOLD  = 400;
    localparam int          RAND_BEATS = 400;
    localparam int          QUIET_FROM = 350;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] sym;
        logic [6:0] na;
        logic [6:0] nb;
    } nfa_entry_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] entry_index;
        logic [1:0] entry_kind;
        logic [7:0] entry_symbol;
        logic [6:0] next_a;
        logic [6:0] next_b;
        logic [7:0] symbol;
    } beat_t;

    typedef struct packed {
        logic matched;
        logic set_empty;
    } verdict_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data     = '0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [1:0] mode         = '0;
    logic [5:0] entry_index  = '0;
    logic [1:0] entry_kind   = '0;
    logic [7:0] entry_symbol = '0;
    logic [6:0] next_a       = '0;
    logic [6:0] next_b       = '0;
    logic [7:0] symbol       = '0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic       matched;
    logic       set_empty;

    // Shadow copy of the matcher state
    nfa_entry_t  nfa_shadow [NUM_STATES];
    logic [63:0] live_states = '0;
    logic [5:0]  start_shadow = '0;

    beat_t    pending_beats [$];
    verdict_t verdicts_due  [$];
    int       beats_queued  = 0;
    int       beats_scored  = 0;
    int       mismatches    = 0;
    int       cycle_cnt     = 0;
    int       tx_gap        = 0;
    int       rx_gap        = 0;
    int       hold_left     = 0;
    bit       hold_req      = 1'b0;
    bit       quiet         = 1'b0;
    bit       in_took       = 1'b0;

    nfa_regex_stream_matcher_unit #(
        .NUM_STATES (NUM_STATES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .entry_index  (entry_index),
        .entry_kind   (entry_kind),
        .entry_symbol (entry_symbol),
        .next_a       (next_a),
        .next_b       (next_b),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .matched      (matched),
        .set_empty    (set_empty)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Add root and everything reachable through split entries
    function automatic logic [63:0] close_over_splits(input logic [63:0] set_in,
                                                      input logic [6:0] root);
        logic [63:0] acc;
        int          stk [NUM_STATES];
        int          sp;
        nfa_entry_t  ent;
        acc = set_in;
        sp  = 0;
        if (root >= SUCC_NONE || acc[root[5:0]])
            return acc;
        acc[root[5:0]] = 1'b1;
        stk[sp] = int'(root[5:0]);
        sp++;
        while (sp > 0)
        begin
            sp--;
            ent = nfa_shadow[stk[sp]];
            if (ent.kind == KIND_SPLIT)
            begin
                if (ent.na < SUCC_NONE && !acc[ent.na[5:0]])
                begin
                    acc[ent.na[5:0]] = 1'b1;
                    stk[sp] = int'(ent.na[5:0]);
                    sp++;
                end
                if (ent.nb < SUCC_NONE && !acc[ent.nb[5:0]])
                begin
                    acc[ent.nb[5:0]] = 1'b1;
                    stk[sp] = int'(ent.nb[5:0]);
                    sp++;
                end
            end
        end
        return acc;
    endfunction

    // Advance the shadow state by one beat and score the resulting set
    function automatic verdict_t step_matcher(input beat_t b);
        verdict_t    v;
        logic [63:0] nxt;
        nxt = '0;
        case (b.mode)
            MODE_WRITE:
                nfa_shadow[b.entry_index] = '{b.entry_kind, b.entry_symbol, b.next_a, b.next_b};
            MODE_START:
                live_states = close_over_splits('0, {1'b0, start_shadow});
            MODE_SYMBOL:
            begin
                for (int i = 0; i < NUM_STATES; i++)
                    if (live_states[i] && nfa_shadow[i].kind == KIND_LITERAL
                        && nfa_shadow[i].sym == b.symbol)
                        nxt = close_over_splits(nxt, nfa_shadow[i].na);
                live_states = nxt;
            end
            default: ;
        endcase
        v.matched   = 1'b0;
        v.set_empty = (live_states == '0);
        for (int i = 0; i < NUM_STATES; i++)
            if (live_states[i] && nfa_shadow[i].kind == KIND_MATCH)
                v.matched = 1'b1;
        return v;
    endfunction

    function automatic beat_t rand_beat();
        beat_t b;
        b.mode         = 2'($urandom_range(0, 3));
        b.entry_index  = 6'($urandom_range(0, 63));
        b.entry_kind   = 2'($urandom_range(0, 3));
        b.entry_symbol = 8'($urandom_range(0, 255));
        b.next_a       = 7'($urandom_range(0, 127));
        b.next_b       = 7'($urandom_range(0, 127));
        b.symbol       = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic push_beat(input beat_t b);
        pending_beats.insert(pending_beats.size(), b);
        beats_queued++;
    endtask

    task automatic push_write(input logic [5:0] idx, input logic [1:0] kind,
                              input logic [7:0] sym, input logic [6:0] na,
                              input logic [6:0] nb);
        beat_t b;
        b              = rand_beat();
        b.mode         = MODE_WRITE;
        b.entry_index  = idx;
        b.entry_kind   = kind;
        b.entry_symbol = sym;
        b.next_a       = na;
        b.next_b       = nb;
        push_beat(b);
    endtask

    task automatic push_mode(input logic [1:0] m, input logic [7:0] sym);
        beat_t b;
        b        = rand_beat();
        b.mode   = m;
        b.symbol = sym;
        push_beat(b);
    endtask

    // Wait until every queued beat has produced its result
    task automatic wait_idle();
        do
            @(negedge clk);
        while (beats_scored != beats_queued);
    endtask

    task automatic set_start(input logic [5:0] v);
        @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Input driver: hold the beat until taken, then idle or offer the next one
    always @(negedge clk)
    begin
        beat_t b;
        if (rst_n && (!in_valid || in_took))
        begin
            in_took = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                b = pending_beats.pop_front();
                mode         <= b.mode;
                entry_index  <= b.entry_index;
                entry_kind   <= b.entry_kind;
                entry_symbol <= b.entry_symbol;
                next_a       <= b.next_a;
                next_b       <= b.next_b;
                symbol       <= b.symbol;
                in_valid     <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    tx_gap = $urandom_range(1, 17);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long hold-off of the result side, counted here
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
        begin
            hold_left <= LONG_HOLD;
            hold_req  <= 1'b0;
        end
    end

    // Result side back-pressure in random bursts
    always @(negedge clk)
    begin
        if (!rst_n || hold_left > 0)
            out_ready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            rx_gap = $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Track the register, check results, predict accepted beats
    always @(posedge clk)
    begin
        beat_t    b;
        verdict_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                start_shadow = cfg_data;
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result beat: matched=%0b set_empty=%0b",
                                 matched, set_empty);
                    mismatches++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (want.matched !== matched || want.set_empty !== set_empty)
                    begin
                        if (mismatches < 10)
                            $display("result %0d: want matched=%0b set_empty=%0b, got %0b %0b",
                                     beats_scored, want.matched, want.set_empty,
                                     matched, set_empty);
                        mismatches++;
                    end
                    beats_scored++;
                end
            end
            if (in_valid && in_ready)
            begin
                b = '{mode, entry_index, entry_kind, entry_symbol, next_a, next_b, symbol};
                verdicts_due.insert(verdicts_due.size(), step_matcher(b));
                in_took = 1'b1;
            end
        end
    end

    // Stop a hung run
    initial
    begin
        while (cycle_cnt < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [7:0] alpha [4];
        logic [5:0] s;
        logic [6:0] nb;
        int         len, n_str, ph, base_cnt, p;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Load every table entry so no scan ever meets an unwritten one
        for (int i = 0; i < NUM_STATES; i++)
            push_write(6'(i), 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        wait_idle();
        set_start(6'd0);

        // Literal loop through a split back to a lower index, dead entry, match
        push_mode(MODE_NOP, 8'h00);
        push_write(6'd0, KIND_LITERAL, 8'h00, 7'd1, 7'd127);
        push_write(6'd1, KIND_SPLIT, 8'h00, 7'd2, 7'd4);
        push_write(6'd2, KIND_LITERAL, 8'hFF, 7'd1, 7'd0);
        push_write(6'd3, KIND_DEAD, 8'hFF, 7'd127, 7'd127);
        push_write(6'd4, KIND_MATCH, 8'h00, 7'd64, 7'd64);
        push_mode(MODE_START, 8'h00);
        push_mode(MODE_SYMBOL, 8'h00);
        push_mode(MODE_SYMBOL, 8'hFF);
        push_mode(MODE_SYMBOL, 8'h55);
        push_mode(MODE_SYMBOL, 8'h00);
        push_mode(MODE_START, 8'h00);
        push_write(6'd0, KIND_LITERAL, 8'h55, 7'd3, 7'd64);
        push_mode(MODE_SYMBOL, 8'h55);
        push_mode(MODE_SYMBOL, 8'h55);
        push_mode(MODE_NOP, 8'hFF);
        wait_idle();
        set_start(6'd63);

        // Splits with no successor, self loop, start state that is the match
        push_write(6'd63, KIND_SPLIT, 8'hAA, 7'd127, 7'd64);
        push_mode(MODE_START, 8'h00);
        push_write(6'd62, KIND_MATCH, 8'hAA, 7'd0, 7'd0);
        push_write(6'd63, KIND_SPLIT, 8'hAA, 7'd62, 7'd63);
        push_mode(MODE_START, 8'h00);
        push_mode(MODE_SYMBOL, 8'hAA);
        push_write(6'd63, KIND_MATCH, 8'h00, 7'd64, 7'd64);
        push_mode(MODE_START, 8'h00);
        push_mode(MODE_NOP, 8'h00);

        // Random programs rooted at the start state, then strings over their alphabet
        base_cnt = beats_queued;
        ph = 0;
        while (beats_queued - base_cnt < RAND_BEATS)
        begin
            wait_idle();
            if (ph % 5 == 0)
                s = 6'd0;
            else if (ph % 5 == 1)
                s = 6'd63;
            else
                s = 6'($urandom_range(0, 63));
            set_start(s);
            if (beats_queued - base_cnt >= QUIET_FROM)
                quiet = 1'b1;
            if (ph == 3)
                hold_req = 1'b1;
            len = $urandom_range(2, 8);
            for (int k = 0; k < 4; k++)
                alpha[k] = 8'($urandom_range(0, 255));
            for (int j = 0; j < len; j++)
            begin
                p = (s + j) % 64;
                if ($urandom_range(0, 9) < 6)
                    push_write(6'(p), KIND_LITERAL, alpha[$urandom_range(0, 3)],
                               7'((s + j + 1) % 64), 7'($urandom_range(0, 127)));
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                        nb = 7'(SUCC_NONE + $urandom_range(0, 63));
                    else
                        nb = 7'((s + $urandom_range(0, len)) % 64);
                    push_write(6'(p), KIND_SPLIT, 8'($urandom_range(0, 255)),
                               7'((s + j + 1) % 64), nb);
                end
            end
            push_write(6'((s + len) % 64), KIND_MATCH, 8'($urandom_range(0, 255)),
                       7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            n_str = $urandom_range(2, 5);
            for (int st = 0; st < n_str; st++)
            begin
                // Let the matcher drain once before the sender carries on
                if (ph == 5 && st == 1)
                    wait_idle();
                push_mode(MODE_START, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 10))
                begin
                    if ($urandom_range(0, 9) == 0)
                        push_beat(rand_beat());
                    else if ($urandom_range(0, 99) < 85)
                        push_mode(MODE_SYMBOL, alpha[$urandom_range(0, 3)]);
                    else
                        push_mode(MODE_SYMBOL, 8'($urandom_range(0, 255)));
                end
            end
            ph++;
        end

        wait_idle();
        repeat (NUM_STATES + 8) @(posedge clk);
        mismatches += verdicts_due.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
design/nrsm_pkg.sv
design/nfa_regex_stream_matcher_unit.sv
design/nrsm_checker.sv
test/nfa_regex_stream_matcher_unit_tb.sv
